// ===== sv/fptq_pkg.sv =====
`timescale 1ns / 1ps
// Types and codes shared by the frame packing transmit queue.
// No dependencies; imported by frame_packing_tx_queue_core.
package fptq_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DROP   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic [7:0] frame_len;
    logic       first_of_frame;
  } fptq_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_byte;
    logic [7:0] packet_len;
    logic       end_of_packet;
    logic [8:0] packets_queued;
  } fptq_out_t;

endpackage

// ===== sv/frame_packing_tx_queue_core.sv =====
`timescale 1ns / 1ps
// Frame packing transmit queue: packet slot ring with first-fit frame packing.
// Depends on fptq_pkg (transfer structs, opcode and status codes).
// A first-of-frame push walks the slot length memory, one compare per cycle,
// from the oldest packet on, and opens a new slot when no packet has room.
// Next transfer may start the cycle the result strobe is high; no clearing pass.
// Reset (sync, active low) empties the ring; results cannot be stalled.
module frame_packing_tx_queue_core #(
  parameter int SLOTS        = 16,
  parameter int PACKET_BYTES = 64,
  parameter int HEADER_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fptq_pkg::fptq_in_t  in_data,
  output logic                out_strobe,
  output fptq_pkg::fptq_out_t out_data
);
  import fptq_pkg::*;

  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int DEPTH = SLOTS * PACKET_BYTES;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [AW-1:0] PB_A  = AW'(PACKET_BYTES);
  localparam logic [7:0]    HDR   = 8'(HEADER_BYTES);
  localparam logic [8:0]    PB_9  = 9'(PACKET_BYTES);
  localparam logic [8:0]    HDR_9 = 9'(HEADER_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_SCMP = 3'd2;
  localparam logic [2:0] S_NEW  = 3'd3;
  localparam logic [2:0] S_PULL = 3'd4;

  function automatic logic [SW-1:0] nxt_slot(input logic [SW-1:0] s);
    nxt_slot = (s == SW'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  logic [2:0]    state_r, state_nxt;
  fptq_in_t      in_r, in_nxt;
  logic [SW-1:0] head_r, head_nxt;
  logic [SW-1:0] tail_r, tail_nxt;
  logic [SW-1:0] wslot_r, wslot_nxt;
  logic [SW-1:0] sidx_r, sidx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] sn_r, sn_nxt;
  logic [7:0]    woff_r, woff_nxt;
  logic [7:0]    roff_r, roff_nxt;
  logic [7:0]    due_r, due_nxt;
  fptq_out_t     out_r, out_nxt;
  logic          ostb_r, ostb_nxt;

  logic [7:0]    slot_len_mem [SLOTS];
  logic [7:0]    store_mem [DEPTH];
  logic [7:0]    len_rd_r;
  logic [7:0]    st_rd_r;

  logic [SW-1:0] len_raddr;
  logic [AW-1:0] st_raddr;
  logic          len_we;
  logic [7:0]    len_wdata;
  logic          st_we;
  logic [SW-1:0] wr_slot;
  logic [7:0]    wr_off;
  logic [AW-1:0] st_waddr;
  logic          too_long;
  logic          fits;
  logic [7:0]    roff_inc;

  // The search walk reads one slot ahead so the next slot length is ready for its compare
  assign len_raddr = (state_r == S_SCMP) ? nxt_slot(sidx_r) : tail_r;
  assign st_raddr  = AW'(tail_r) * PB_A + AW'(roff_r);
  assign st_waddr  = AW'(wr_slot) * PB_A + AW'(wr_off);

  assign too_long = (in_r.frame_len == 8'd0) || ((HDR_9 + {1'b0, in_r.frame_len}) > PB_9);
  assign fits     = ({1'b0, len_rd_r} + {1'b0, in_r.frame_len}) <= PB_9;
  assign roff_inc = roff_r + 8'd1;

  always_comb begin
    state_nxt = state_r;
    in_nxt    = in_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    wslot_nxt = wslot_r;
    sidx_nxt  = sidx_r;
    cnt_nxt   = cnt_r;
    sn_nxt    = sn_r;
    woff_nxt  = woff_r;
    roff_nxt  = roff_r;
    due_nxt   = due_r;
    out_nxt   = out_r;
    ostb_nxt  = 1'b0;
    len_we    = 1'b0;
    len_wdata = len_rd_r + in_r.frame_len;
    st_we     = 1'b0;
    wr_slot   = wslot_r;
    wr_off    = woff_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt    = in_data;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (in_r.opcode == OP_PULL) begin
          if (cnt_r == '0) begin
            out_nxt        = '0;
            out_nxt.status = ST_EMPTY;
            ostb_nxt       = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_PULL;
          end
        end else if (!in_r.first_of_frame) begin
          out_nxt   = '0;
          ostb_nxt  = 1'b1;
          state_nxt = S_IDLE;
          if (due_r == 8'd0) begin
            out_nxt.status = ST_REJECT;
          end else begin
            st_we          = 1'b1;
            woff_nxt       = woff_r + 8'd1;
            due_nxt        = due_r - 8'd1;
            out_nxt.status = ST_OK;
          end
        end else begin
          // a new frame abandons whatever is still due of the open one
          due_nxt = 8'd0;
          if (too_long) begin
            out_nxt        = '0;
            out_nxt.status = ST_REJECT;
            ostb_nxt       = 1'b1;
            state_nxt      = S_IDLE;
          end else if (cnt_r == '0) begin
            state_nxt = S_NEW;
          end else begin
            sidx_nxt  = tail_r;
            sn_nxt    = '0;
            state_nxt = S_SCMP;
          end
        end
      end
      S_SCMP: begin
        if (fits) begin
          len_we         = 1'b1;
          wr_slot        = sidx_r;
          len_wdata      = len_rd_r + in_r.frame_len;
          st_we          = 1'b1;
          wr_off         = len_rd_r;
          wslot_nxt      = sidx_r;
          woff_nxt       = len_rd_r + 8'd1;
          due_nxt        = in_r.frame_len - 8'd1;
          out_nxt        = '0;
          out_nxt.status = ST_OK;
          ostb_nxt       = 1'b1;
          state_nxt      = S_IDLE;
        end else if (sn_r == CW'(cnt_r - 1'b1)) begin
          state_nxt = S_NEW;
        end else begin
          sidx_nxt = nxt_slot(sidx_r);
          sn_nxt   = sn_r + 1'b1;
        end
      end
      S_NEW: begin
        out_nxt = '0;
        if (cnt_r == CW'(SLOTS)) begin
          // ring full: head meets tail, oldest packet goes
          tail_nxt       = nxt_slot(tail_r);
          roff_nxt       = HDR;
          out_nxt.status = ST_DROP;
        end else begin
          cnt_nxt        = cnt_r + 1'b1;
          out_nxt.status = ST_OK;
        end
        len_we    = 1'b1;
        wr_slot   = head_r;
        len_wdata = HDR + in_r.frame_len;
        st_we     = 1'b1;
        wr_off    = HDR;
        wslot_nxt = head_r;
        woff_nxt  = HDR + 8'd1;
        due_nxt   = in_r.frame_len - 8'd1;
        head_nxt  = nxt_slot(head_r);
        ostb_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_PULL: begin
        out_nxt            = '0;
        out_nxt.status     = ST_OK;
        out_nxt.out_byte   = st_rd_r;
        out_nxt.packet_len = len_rd_r;
        if (roff_inc >= len_rd_r) begin
          out_nxt.end_of_packet = 1'b1;
          if (due_r != 8'd0 && wslot_r == tail_r) begin
            due_nxt = 8'd0;
          end
          tail_nxt = nxt_slot(tail_r);
          cnt_nxt  = cnt_r - 1'b1;
          roff_nxt = HDR;
        end else begin
          roff_nxt = roff_inc;
        end
        ostb_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ostb_nxt) begin
      out_nxt.packets_queued = 9'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      wslot_r <= '0;
      cnt_r   <= '0;
      woff_r  <= 8'd0;
      roff_r  <= HDR;
      due_r   <= 8'd0;
      ostb_r  <= 1'b0;
      sidx_r  <= '0;
      sn_r    <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      wslot_r <= wslot_nxt;
      cnt_r   <= cnt_nxt;
      woff_r  <= woff_nxt;
      roff_r  <= roff_nxt;
      due_r   <= due_nxt;
      ostb_r  <= ostb_nxt;
      sidx_r  <= sidx_nxt;
      sn_r    <= sn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      slot_len_mem[wr_slot] <= len_wdata;
    end
    len_rd_r <= slot_len_mem[len_raddr];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= in_r.data_byte;
    end
    st_rd_r <= store_mem[st_raddr];
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = ostb_r;
  assign out_data   = out_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(SLOTS))
    else $error("slot count above ring size");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not start the sequencer");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while sequencer still busy");

  a_eop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.end_of_packet) |-> (out_data.status == ST_OK))
    else $error("end of packet flagged on a failed transfer");
`endif

endmodule
